// ----- design/bal_pkg.sv -----
// Shared types and constants for the bounded array list engine.
// Holds command codes, controller states and the controller/datapath link structs.
// No dependencies.
package bal_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned POS_W     = 5;
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned DEPTH_DEF = 16;
  localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

  localparam logic [2:0] REG_CAPACITY = 3'd0;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND  = 3'd0,
    CMD_INSERT  = 3'd1,
    CMD_DELETE  = 3'd2,
    CMD_REVERSE = 3'd3,
    CMD_SORT    = 3'd4,
    CMD_DUMP    = 3'd5
  } cmd_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_APP_WR,
    S_SH_CHK,
    S_SH_WR,
    S_DEL_RD,
    S_DEL_CAP,
    S_DEL_CHK,
    S_DEL_WR,
    S_REV_CHK,
    S_REV_RDJ,
    S_REV_WRI,
    S_REV_WRJ,
    S_SRT_I,
    S_SRT_A,
    S_SRT_J,
    S_SRT_CMP,
    S_DMP_RD,
    S_DMP_OUT,
    S_FAIL,
    S_DONE,
    S_DEL_DONE
  } state_e;

  typedef enum logic {
    SEL_I,
    SEL_J
  } idx_sel_e;

  typedef enum logic [1:0] {
    WD_VAL,
    WD_RD,
    WD_A
  } wd_sel_e;

  typedef enum logic [2:0] {
    I_HOLD,
    I_COUNT,
    I_POSM1,
    I_ZERO,
    I_INC,
    I_DEC
  } i_op_e;

  typedef enum logic [2:0] {
    J_HOLD,
    J_CNTM1,
    J_POS,
    J_IP1,
    J_INC,
    J_DEC
  } j_op_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_e;

  typedef enum logic [1:0] {
    DSEL_ZERO,
    DSEL_A,
    DSEL_RD
  } dsel_e;

  typedef struct packed {
    logic     accept;
    logic     rd_en;
    idx_sel_e rd_sel;
    logic     wr_en;
    idx_sel_e wr_sel;
    wd_sel_e  wd_sel;
    i_op_e    i_op;
    j_op_e    j_op;
    logic     a_load;
    cnt_op_e  cnt_op;
    logic     emit;
    logic     emit_ok;
    dsel_e    emit_dsel;
    logic     emit_last;
  } dp_ctl_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             ins_ok;
    logic             full;
    logic             del_ok;
    logic             cnt_zero;
    logic             cnt_le1;
    logic             i_ge_pos;
    logic             i_lt_cnt;
    logic             j_lt_cnt;
    logic             i_lt_j;
    logic             a_gt_rd;
    logic             dump_last;
    logic             out_free;
  } dp_sts_t;

endpackage

// ----- design/bounded_array_list_engine.sv -----
// Bounded array list engine: one command at a time; stall goes high after a command is
// accepted and stays high until its last result beat is loaded, and the next command is
// taken the cycle after that. Insert and delete move the entries past pos one word at a
// time, reverse swaps pairs from both ends, sort compares each slot with every later word,
// dump emits one beat per word; a rejected command goes straight to its result beat.
// Reset empties the list and sets capacity to 16; entry contents are not cleared.
module bounded_array_list_engine
  import bal_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [CMD_W-1:0]         cmd_i,
  input  logic [POS_W-1:0]         pos_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     ok_o,
  output logic signed [DATA_W-1:0] data_o,
  output logic [CNT_W-1:0]         count_o,
  output logic                     last_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  logic [CNT_W-1:0] cap_q;
  logic             cap_sel;
  dp_ctl_t          ctl;
  dp_sts_t          sts;

  assign pready  = 1'b1;
  assign cap_sel = ({paddr[2], 2'b00} == REG_CAPACITY);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && cap_sel) begin
      cap_q <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata = cap_sel ? {{(32-CNT_W){1'b0}}, cap_q} : 32'd0;

  bal_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  bal_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .pos_i       (pos_i),
    .value_i     (value_i),
    .cap_i       (cap_q),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ok_o        (ok_o),
    .data_o      (data_o),
    .count_o     (count_o),
    .last_o      (last_o)
  );

endmodule

// ----- design/bal_ctrl.sv -----
// Command sequencer for the bounded array list engine.
// Walks each command through read, write and result steps on the datapath.
// Depends on bal_pkg.
module bal_ctrl
  import bal_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  dp_sts_t sts_i,
  output dp_ctl_t ctl_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d           = state_q;
    ctl_o.accept      = 1'b0;
    ctl_o.rd_en       = 1'b0;
    ctl_o.rd_sel      = SEL_I;
    ctl_o.wr_en       = 1'b0;
    ctl_o.wr_sel      = SEL_I;
    ctl_o.wd_sel      = WD_VAL;
    ctl_o.i_op        = I_HOLD;
    ctl_o.j_op        = J_HOLD;
    ctl_o.a_load      = 1'b0;
    ctl_o.cnt_op      = CNT_HOLD;
    ctl_o.emit        = 1'b0;
    ctl_o.emit_ok     = 1'b0;
    ctl_o.emit_dsel   = DSEL_ZERO;
    ctl_o.emit_last   = 1'b1;
    in_stall_o        = (state_q != S_IDLE);

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.accept = 1'b1;
          state_d      = S_DECODE;
        end
      end

      S_DECODE: begin
        unique case (sts_i.cmd)
          CMD_APPEND: begin
            if (sts_i.full) begin
              state_d = S_FAIL;
            end else begin
              ctl_o.i_op = I_COUNT;
              state_d    = S_APP_WR;
            end
          end
          CMD_INSERT: begin
            if (!sts_i.ins_ok) begin
              state_d = S_FAIL;
            end else begin
              ctl_o.i_op = I_COUNT;
              ctl_o.j_op = J_CNTM1;
              state_d    = S_SH_CHK;
            end
          end
          CMD_DELETE: begin
            if (!sts_i.del_ok) begin
              state_d = S_FAIL;
            end else begin
              ctl_o.i_op = I_POSM1;
              ctl_o.j_op = J_POS;
              state_d    = S_DEL_RD;
            end
          end
          CMD_REVERSE: begin
            if (sts_i.cnt_le1) begin
              state_d = S_DONE;
            end else begin
              ctl_o.i_op = I_ZERO;
              ctl_o.j_op = J_CNTM1;
              state_d    = S_REV_CHK;
            end
          end
          CMD_SORT: begin
            ctl_o.i_op = I_ZERO;
            state_d    = S_SRT_I;
          end
          CMD_DUMP: begin
            if (sts_i.cnt_zero) begin
              state_d = S_FAIL;
            end else begin
              ctl_o.i_op = I_ZERO;
              state_d    = S_DMP_RD;
            end
          end
          default: begin
            state_d = S_FAIL;
          end
        endcase
      end

      S_APP_WR: begin
        ctl_o.wr_en  = 1'b1;
        ctl_o.wr_sel = SEL_I;
        ctl_o.wd_sel = WD_VAL;
        ctl_o.cnt_op = CNT_INC;
        state_d      = S_DONE;
      end

      S_SH_CHK: begin
        if (sts_i.i_ge_pos) begin
          ctl_o.rd_en  = 1'b1;
          ctl_o.rd_sel = SEL_J;
          state_d      = S_SH_WR;
        end else begin
          ctl_o.wr_en  = 1'b1;
          ctl_o.wr_sel = SEL_I;
          ctl_o.wd_sel = WD_VAL;
          ctl_o.cnt_op = CNT_INC;
          state_d      = S_DONE;
        end
      end

      S_SH_WR: begin
        ctl_o.wr_en  = 1'b1;
        ctl_o.wr_sel = SEL_I;
        ctl_o.wd_sel = WD_RD;
        ctl_o.i_op   = I_DEC;
        ctl_o.j_op   = J_DEC;
        state_d      = S_SH_CHK;
      end

      S_DEL_RD: begin
        ctl_o.rd_en  = 1'b1;
        ctl_o.rd_sel = SEL_I;
        state_d      = S_DEL_CAP;
      end

      S_DEL_CAP: begin
        ctl_o.a_load = 1'b1;
        state_d      = S_DEL_CHK;
      end

      S_DEL_CHK: begin
        if (sts_i.j_lt_cnt) begin
          ctl_o.rd_en  = 1'b1;
          ctl_o.rd_sel = SEL_J;
          state_d      = S_DEL_WR;
        end else begin
          ctl_o.cnt_op = CNT_DEC;
          state_d      = S_DEL_DONE;
        end
      end

      S_DEL_WR: begin
        ctl_o.wr_en  = 1'b1;
        ctl_o.wr_sel = SEL_I;
        ctl_o.wd_sel = WD_RD;
        ctl_o.i_op   = I_INC;
        ctl_o.j_op   = J_INC;
        state_d      = S_DEL_CHK;
      end

      S_REV_CHK: begin
        if (sts_i.i_lt_j) begin
          ctl_o.rd_en  = 1'b1;
          ctl_o.rd_sel = SEL_I;
          state_d      = S_REV_RDJ;
        end else begin
          state_d = S_DONE;
        end
      end

      S_REV_RDJ: begin
        ctl_o.a_load = 1'b1;
        ctl_o.rd_en  = 1'b1;
        ctl_o.rd_sel = SEL_J;
        state_d      = S_REV_WRI;
      end

      S_REV_WRI: begin
        ctl_o.wr_en  = 1'b1;
        ctl_o.wr_sel = SEL_I;
        ctl_o.wd_sel = WD_RD;
        state_d      = S_REV_WRJ;
      end

      S_REV_WRJ: begin
        ctl_o.wr_en  = 1'b1;
        ctl_o.wr_sel = SEL_J;
        ctl_o.wd_sel = WD_A;
        ctl_o.i_op   = I_INC;
        ctl_o.j_op   = J_DEC;
        state_d      = S_REV_CHK;
      end

      S_SRT_I: begin
        if (sts_i.i_lt_cnt) begin
          ctl_o.rd_en  = 1'b1;
          ctl_o.rd_sel = SEL_I;
          ctl_o.j_op   = J_IP1;
          state_d      = S_SRT_A;
        end else begin
          state_d = S_DONE;
        end
      end

      S_SRT_A: begin
        ctl_o.a_load = 1'b1;
        state_d      = S_SRT_J;
      end

      S_SRT_J: begin
        if (sts_i.j_lt_cnt) begin
          ctl_o.rd_en  = 1'b1;
          ctl_o.rd_sel = SEL_J;
          state_d      = S_SRT_CMP;
        end else begin
          // settle the running minimum into slot i
          ctl_o.wr_en  = 1'b1;
          ctl_o.wr_sel = SEL_I;
          ctl_o.wd_sel = WD_A;
          ctl_o.i_op   = I_INC;
          state_d      = S_SRT_I;
        end
      end

      S_SRT_CMP: begin
        if (sts_i.a_gt_rd) begin
          ctl_o.wr_en  = 1'b1;
          ctl_o.wr_sel = SEL_J;
          ctl_o.wd_sel = WD_A;
          ctl_o.a_load = 1'b1;
        end
        ctl_o.j_op = J_INC;
        state_d    = S_SRT_J;
      end

      S_DMP_RD: begin
        ctl_o.rd_en  = 1'b1;
        ctl_o.rd_sel = SEL_I;
        state_d      = S_DMP_OUT;
      end

      S_DMP_OUT: begin
        if (sts_i.out_free) begin
          ctl_o.emit      = 1'b1;
          ctl_o.emit_ok   = 1'b1;
          ctl_o.emit_dsel = DSEL_RD;
          ctl_o.emit_last = sts_i.dump_last;
          ctl_o.i_op      = I_INC;
          state_d         = sts_i.dump_last ? S_IDLE : S_DMP_RD;
        end
      end

      S_FAIL: begin
        if (sts_i.out_free) begin
          ctl_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end

      S_DONE: begin
        if (sts_i.out_free) begin
          ctl_o.emit    = 1'b1;
          ctl_o.emit_ok = 1'b1;
          state_d       = S_IDLE;
        end
      end

      S_DEL_DONE: begin
        if (sts_i.out_free) begin
          ctl_o.emit      = 1'b1;
          ctl_o.emit_ok   = 1'b1;
          ctl_o.emit_dsel = DSEL_A;
          state_d         = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ----- design/bal_dpath.sv -----
// Datapath for the bounded array list engine: entry memory, walk indices,
// holding word, entry count and the result register. Driven by bal_ctrl.
// Depends on bal_pkg.
module bal_dpath
  import bal_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [CMD_W-1:0]         cmd_i,
  input  logic [POS_W-1:0]         pos_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic [CNT_W-1:0]         cap_i,
  input  dp_ctl_t                  ctl_i,
  output dp_sts_t                  sts_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     ok_o,
  output logic signed [DATA_W-1:0] data_o,
  output logic [CNT_W-1:0]         count_o,
  output logic                     last_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic signed [DATA_W-1:0] mem [DEPTH];

  logic [CMD_W-1:0]         cmd_q;
  logic [POS_W-1:0]         pos_q;
  logic signed [DATA_W-1:0] val_q;
  logic signed [DATA_W-1:0] rd_q;
  logic signed [DATA_W-1:0] a_q;
  logic [CNT_W-1:0]         i_q, i_d;
  logic [CNT_W-1:0]         j_q, j_d;
  logic [CNT_W-1:0]         count_q, count_d;

  logic                     out_valid_q;
  logic                     ok_q;
  logic signed [DATA_W-1:0] data_q;
  logic [CNT_W-1:0]         cnt_out_q;
  logic                     last_q;

  logic [CNT_W-1:0]         rd_idx, wr_idx;
  logic [AW+CNT_W-1:0]      rd_ext, wr_ext;
  logic [AW-1:0]            rd_addr, wr_addr;
  logic signed [DATA_W-1:0] wr_data;
  logic signed [DATA_W-1:0] emit_data;
  logic [CNT_W:0]           count_p1;
  logic [CNT_W:0]           i_p1;
  logic                     out_free;

  assign rd_idx  = (ctl_i.rd_sel == SEL_I) ? i_q : j_q;
  assign wr_idx  = (ctl_i.wr_sel == SEL_I) ? i_q : j_q;
  assign rd_ext  = {{AW{1'b0}}, rd_idx};
  assign wr_ext  = {{AW{1'b0}}, wr_idx};
  assign rd_addr = rd_ext[AW-1:0];
  assign wr_addr = wr_ext[AW-1:0];

  always_comb begin
    unique case (ctl_i.wd_sel)
      WD_VAL:  wr_data = val_q;
      WD_RD:   wr_data = rd_q;
      WD_A:    wr_data = a_q;
      default: wr_data = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      cmd_q <= cmd_i;
      pos_q <= pos_i;
      val_q <= value_i;
    end
    if (ctl_i.a_load) begin
      a_q <= rd_q;
    end
    i_q <= i_d;
    j_q <= j_d;
  end

  always_comb begin
    unique case (ctl_i.i_op)
      I_HOLD:  i_d = i_q;
      I_COUNT: i_d = count_q;
      I_POSM1: i_d = pos_q - CNT_W'(1);
      I_ZERO:  i_d = '0;
      I_INC:   i_d = i_q + CNT_W'(1);
      I_DEC:   i_d = i_q - CNT_W'(1);
      default: i_d = i_q;
    endcase
  end

  always_comb begin
    unique case (ctl_i.j_op)
      J_HOLD:  j_d = j_q;
      J_CNTM1: j_d = count_q - CNT_W'(1);
      J_POS:   j_d = pos_q;
      J_IP1:   j_d = i_q + CNT_W'(1);
      J_INC:   j_d = j_q + CNT_W'(1);
      J_DEC:   j_d = j_q - CNT_W'(1);
      default: j_d = j_q;
    endcase
  end

  always_comb begin
    unique case (ctl_i.cnt_op)
      CNT_HOLD: count_d = count_q;
      CNT_INC:  count_d = count_q + CNT_W'(1);
      CNT_DEC:  count_d = count_q - CNT_W'(1);
      default:  count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    unique case (ctl_i.emit_dsel)
      DSEL_ZERO: emit_data = '0;
      DSEL_A:    emit_data = a_q;
      DSEL_RD:   emit_data = rd_q;
      default:   emit_data = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.emit) begin
      ok_q      <= ctl_i.emit_ok;
      data_q    <= emit_data;
      cnt_out_q <= count_q;
      last_q    <= ctl_i.emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign ok_o        = ok_q;
  assign data_o      = data_q;
  assign count_o     = cnt_out_q;
  assign last_o      = last_q;

  assign count_p1 = {1'b0, count_q} + (CNT_W+1)'(1);
  assign i_p1     = {1'b0, i_q} + (CNT_W+1)'(1);

  always_comb begin
    sts_o.cmd       = cmd_q;
    sts_o.full      = (count_q >= cap_i) || (32'(count_q) >= DEPTH);
    sts_o.ins_ok    = !sts_o.full && (pos_q != '0) && ({1'b0, pos_q} <= count_p1);
    sts_o.del_ok    = (count_q != '0) && (pos_q != '0) && (pos_q <= count_q);
    sts_o.cnt_zero  = (count_q == '0);
    sts_o.cnt_le1   = (count_q <= CNT_W'(1));
    sts_o.i_ge_pos  = (i_q >= pos_q);
    sts_o.i_lt_cnt  = (i_q < count_q);
    sts_o.j_lt_cnt  = (j_q < count_q);
    sts_o.i_lt_j    = (i_q < j_q);
    sts_o.a_gt_rd   = (a_q > rd_q);
    sts_o.dump_last = (i_p1 == {1'b0, count_q});
    sts_o.out_free  = out_free;
  end

  a_emit_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.emit |-> out_free)
    else $error("result loaded while previous beat still held");

  a_rd_in_list : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.rd_en |-> (rd_idx < count_q))
    else $error("read beyond the held entries");

  a_wr_in_list : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.wr_en |-> (wr_idx <= count_q) && (32'(wr_idx) < DEPTH))
    else $error("write beyond the list end");

  a_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      ((count_q == $past(count_q) + CNT_W'(1)) || (count_q == $past(count_q) - CNT_W'(1))))
    else $error("entry count moved by more than one");

endmodule

// ----- sim/tb_bounded_array_list_engine.sv -----
// Self-checking testbench for the bounded array list engine: directed and random command
// streams against a shadow list, with random gaps on the command side and stalls on results.
// Depends on bal_pkg and bounded_array_list_engine.
`timescale 1ns / 1ps

module tb_bounded_array_list_engine;
  import bal_pkg::*;

  localparam logic [CMD_W-1:0] CMD_RSVD_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD_B = 3'd7;
  localparam logic [31:0]      WORD_MIN   = 32'h8000_0000;
  localparam logic [31:0]      WORD_MAX   = 32'h7FFF_FFFF;
  localparam logic [31:0]      WORD_ONES  = 32'hFFFF_FFFF;

  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] data;
    logic [CNT_W-1:0]  count;
    logic              last;
  } list_beat_t;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_stall_o;
  logic [CMD_W-1:0]         cmd_i       = '0;
  logic [POS_W-1:0]         pos_i       = '0;
  logic signed [DATA_W-1:0] value_i     = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic                     ok_o;
  logic signed [DATA_W-1:0] data_o;
  logic [CNT_W-1:0]         count_o;
  logic                     last_o;
  logic                     psel        = 1'b0;
  logic                     penable     = 1'b0;
  logic                     pwrite      = 1'b0;
  logic [2:0]               paddr       = '0;
  logic [31:0]              pwdata      = '0;
  logic [31:0]              prdata;
  logic                     pready;

  list_beat_t        pending_beats[$];
  logic [DATA_W-1:0] shadow_words[DEPTH_DEF];
  int                shadow_len    = 0;
  int                shadow_cap    = 16;
  int                fail_count    = 0;
  int                in_idle_pct   = 20;
  int                out_stall_pct = 20;
  int                stall_left    = 0;

  bounded_array_list_engine i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int pick_gap(input int pct);
    if (pct == 0 || $urandom_range(99, 0) >= pct) return 0;
    if ($urandom_range(9, 0) == 0) return $urandom_range(40, 12);
    return $urandom_range(3, 1);
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(15, 0))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return '0;
      3: return WORD_ONES;
      default: return $urandom();
    endcase
  endfunction

  function automatic void expect_beat(input logic ok, input logic [DATA_W-1:0] data,
                                      input logic last);
    list_beat_t b;
    b.ok    = ok;
    b.data  = data;
    b.count = shadow_len[CNT_W-1:0];
    b.last  = last;
    pending_beats.push_back(b);
  endfunction

  function automatic void predict_command(input logic [CMD_W-1:0] op,
                                          input logic [POS_W-1:0] at,
                                          input logic [DATA_W-1:0] word);
    int lim;
    int p;
    int k;
    int m;
    logic [DATA_W-1:0] held;
    lim = (shadow_cap < DEPTH_DEF) ? shadow_cap : DEPTH_DEF;
    p   = int'(at);
    case (op)
      CMD_APPEND: begin
        if (shadow_len >= lim) begin
          expect_beat(1'b0, '0, 1'b1);
        end else begin
          shadow_words[shadow_len] = word;
          shadow_len++;
          expect_beat(1'b1, '0, 1'b1);
        end
      end
      CMD_INSERT: begin
        if (shadow_len >= lim || p < 1 || p > shadow_len + 1) begin
          expect_beat(1'b0, '0, 1'b1);
        end else begin
          for (k = shadow_len; k > p - 1; k--) shadow_words[k] = shadow_words[k-1];
          shadow_words[p-1] = word;
          shadow_len++;
          expect_beat(1'b1, '0, 1'b1);
        end
      end
      CMD_DELETE: begin
        if (shadow_len == 0 || p < 1 || p > shadow_len) begin
          expect_beat(1'b0, '0, 1'b1);
        end else begin
          held = shadow_words[p-1];
          for (k = p; k < shadow_len; k++) shadow_words[k-1] = shadow_words[k];
          shadow_len--;
          expect_beat(1'b1, held, 1'b1);
        end
      end
      CMD_REVERSE: begin
        for (k = 0; k < shadow_len / 2; k++) begin
          held = shadow_words[k];
          shadow_words[k] = shadow_words[shadow_len-1-k];
          shadow_words[shadow_len-1-k] = held;
        end
        expect_beat(1'b1, '0, 1'b1);
      end
      CMD_SORT: begin
        for (k = 0; k < shadow_len; k++) begin
          for (m = k + 1; m < shadow_len; m++) begin
            if ($signed(shadow_words[k]) > $signed(shadow_words[m])) begin
              held = shadow_words[k];
              shadow_words[k] = shadow_words[m];
              shadow_words[m] = held;
            end
          end
        end
        expect_beat(1'b1, '0, 1'b1);
      end
      CMD_DUMP: begin
        if (shadow_len == 0) begin
          expect_beat(1'b0, '0, 1'b1);
        end else begin
          for (k = 0; k < shadow_len; k++)
            expect_beat(1'b1, shadow_words[k], k == shadow_len - 1);
        end
      end
      default: begin
        expect_beat(1'b0, '0, 1'b1);
      end
    endcase
  endfunction

  task automatic send_cmd(input logic [CMD_W-1:0] op, input logic [POS_W-1:0] at,
                          input logic [DATA_W-1:0] word);
    int gap;
    gap = pick_gap(in_idle_pct);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_i      <= op;
    pos_i      <= at;
    value_i    <= word;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    predict_command(op, at, word);
  endtask

  task automatic settle_list();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending_beats.size() == 0);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_capacity(input int cap);
    logic [31:0] rd;
    settle_list();
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= REG_CAPACITY;
    pwdata  <= 32'(cap);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    shadow_cap = cap;
    @(negedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[CNT_W-1:0] !== cap[CNT_W-1:0]) begin
      $error("capacity: expected %0d, got %0d", cap, rd[CNT_W-1:0]);
      fail_count++;
    end
  endtask

  // hold stall for bursts; leave quiet stretches between them
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (out_stall_pct != 0 && $urandom_range(99, 0) < out_stall_pct) begin
      out_stall_i <= 1'b1;
      stall_left = pick_gap(100) - 1;
    end else begin
      out_stall_i <= 1'b0;
      stall_left = $urandom_range(6, 0);
    end
  end

  always @(posedge clk_i) begin : check_beat
    list_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_beats.size() == 0) begin
        $error("unexpected beat: ok=%0b data=%0h count=%0d last=%0b",
               ok_o, data_o, count_o, last_o);
        fail_count++;
      end else begin
        want = pending_beats.pop_front();
        if (ok_o !== want.ok) begin
          $error("ok: expected %0b, got %0b", want.ok, ok_o);
          fail_count++;
        end
        if (data_o !== want.data) begin
          $error("data: expected %0h, got %0h", want.data, data_o);
          fail_count++;
        end
        if (count_o !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, count_o);
          fail_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last_o);
          fail_count++;
        end
      end
    end
  end

  task automatic test_empty_list();
    send_cmd(CMD_DUMP, 5'd0, '0);
    send_cmd(CMD_DELETE, 5'd1, '0);
    send_cmd(CMD_REVERSE, 5'd0, '0);
    send_cmd(CMD_SORT, 5'd0, '0);
    send_cmd(CMD_APPEND, 5'd0, WORD_MIN);
    send_cmd(CMD_REVERSE, 5'd0, '0);
    send_cmd(CMD_SORT, 5'd0, '0);
    send_cmd(CMD_DUMP, 5'd0, '0);
  endtask

  task automatic test_positions();
    send_cmd(CMD_APPEND, 5'd0, WORD_MAX);
    send_cmd(CMD_INSERT, 5'd1, WORD_ONES);
    send_cmd(CMD_INSERT, 5'd4, '0);
    send_cmd(CMD_INSERT, 5'd0, 32'h1234_5678);
    send_cmd(CMD_INSERT, 5'd6, 32'h1234_5678);
    send_cmd(CMD_INSERT, 5'd31, 32'h5555_5555);
    send_cmd(CMD_INSERT, 5'd3, 32'hAAAA_AAAA);
    send_cmd(CMD_DELETE, 5'd0, '0);
    send_cmd(CMD_DELETE, 5'd31, WORD_ONES);
    send_cmd(CMD_DELETE, 5'd6, '0);
    send_cmd(CMD_SORT, 5'd0, '0);
    send_cmd(CMD_DUMP, 5'd0, '0);
    send_cmd(CMD_DELETE, 5'd5, '0);
    send_cmd(CMD_DELETE, 5'd1, '0);
    send_cmd(CMD_DELETE, 5'd2, '0);
    send_cmd(CMD_REVERSE, 5'd0, '0);
    send_cmd(CMD_DUMP, 5'd0, '0);
  endtask

  task automatic test_reserved_cmds();
    send_cmd(CMD_RSVD_A, 5'd31, WORD_ONES);
    send_cmd(CMD_RSVD_B, 5'd1, '0);
  endtask

  task automatic test_capacity_limits();
    write_capacity(1);
    send_cmd(CMD_APPEND, 5'd0, rand_word());
    send_cmd(CMD_INSERT, 5'd1, rand_word());
    send_cmd(CMD_DELETE, 5'd1, '0);
    send_cmd(CMD_DUMP, 5'd0, '0);
    write_capacity(16);
    out_stall_pct = 40;
    while (shadow_len < DEPTH_DEF) send_cmd(CMD_APPEND, 5'd0, rand_word());
    send_cmd(CMD_APPEND, 5'd0, rand_word());
    send_cmd(CMD_INSERT, 5'd1, rand_word());
    send_cmd(CMD_SORT, 5'd0, '0);
    send_cmd(CMD_DUMP, 5'd0, '0);
    send_cmd(CMD_REVERSE, 5'd0, '0);
    send_cmd(CMD_DUMP, 5'd0, '0);
  endtask

  task automatic run_random_phase(input int cap, input int items, input int in_pct,
                                  input int out_pct);
    int r;
    logic [CMD_W-1:0] op;
    logic [POS_W-1:0] at;
    write_capacity(cap);
    in_idle_pct   = in_pct;
    out_stall_pct = out_pct;
    repeat (items) begin
      r  = $urandom_range(99, 0);
      at = POS_W'($urandom_range(31, 0));
      if (r < 28) begin
        op = CMD_APPEND;
      end else if (r < 48) begin
        op = CMD_INSERT;
        if ($urandom_range(9, 0) != 0) at = POS_W'($urandom_range(shadow_len + 1, 1));
      end else if (r < 68) begin
        op = CMD_DELETE;
        if (shadow_len > 0 && $urandom_range(9, 0) != 0) begin
          at = POS_W'($urandom_range(shadow_len, 1));
        end
      end else if (r < 76) begin
        op = CMD_REVERSE;
      end else if (r < 84) begin
        op = CMD_SORT;
      end else if (r < 93) begin
        op = CMD_DUMP;
      end else if (r < 96) begin
        op = $urandom_range(1, 0) ? CMD_RSVD_A : CMD_RSVD_B;
      end else begin
        op = CMD_W'($urandom_range(7, 0));
      end
      send_cmd(op, at, rand_word());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_empty_list();
    test_positions();
    test_reserved_cmds();
    test_capacity_limits();
    run_random_phase(16, 25, 30, 30);
    run_random_phase(1, 15, 0, 0);
    run_random_phase($urandom_range(15, 2), 25, 50, 50);
    run_random_phase(8, 20, 20, 60);
    run_random_phase(16, 20, 10, 10);
    settle_list();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/bal_pkg.sv
design/bal_ctrl.sv
design/bal_dpath.sv
design/bounded_array_list_engine.sv
sim/tb_bounded_array_list_engine.sv
